>>> design/erbt_pkg.sv
// Shared types, constants and tables for the rigid-body node transform.
package erbt_pkg;

    // Fixed widths of the angle path and the matrix entries
    localparam int ANG_W   = 26;
    localparam int ENT_W   = 20;
    localparam int P18_W   = 22;
    localparam int PROD_W  = 2 * ENT_W;
    localparam int STEP_W  = 5;
    localparam int CX_W    = 34;
    localparam int CZ_W    = 33;
    localparam int AW_W    = 35;
    localparam int MIDX_W  = 4;
    localparam int MAT_STEPS = 15;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [AW_W-1:0] ANG_HALF    = 35'sd3019898880;
    localparam logic signed [AW_W-1:0] ANG_FULL    = 35'sd6039797760;
    localparam logic signed [AW_W-1:0] ANG_QTR     = 35'sd1509949440;
    localparam logic signed [CX_W-1:0] UNIT_POS    = 34'sd262144;
    localparam logic signed [CX_W-1:0] UNIT_NEG    = -34'sd262144;
    localparam logic signed [P18_W+1-1:0] ENT_MAX  = 23'sd524287;
    localparam logic signed [P18_W+1-1:0] ENT_MIN  = -23'sd524288;

    typedef logic signed [ENT_W-1:0] t_ent;

    // Matrix operand selects
    typedef logic [2:0] t_sel;
    localparam t_sel SEL_SR   = 3'd0;
    localparam t_sel SEL_CR   = 3'd1;
    localparam t_sel SEL_SP   = 3'd2;
    localparam t_sel SEL_CP   = 3'd3;
    localparam t_sel SEL_SY   = 3'd4;
    localparam t_sel SEL_CY   = 3'd5;
    localparam t_sel SEL_CYSP = 3'd6;
    localparam t_sel SEL_SYSP = 3'd7;

    // Matrix step operations
    typedef logic [2:0] t_mop;
    localparam t_mop MOP_TMP  = 3'd0;  // keep product as a temporary
    localparam t_mop MOP_LOAD = 3'd1;  // load accumulator
    localparam t_mop MOP_PUT  = 3'd2;  // entry = product
    localparam t_mop MOP_ADD  = 3'd3;  // entry = acc + product
    localparam t_mop MOP_SUB  = 3'd4;  // entry = acc - product
    localparam t_mop MOP_NEG  = 3'd5;  // entry = -sin(pitch)

    typedef struct packed {
        t_sel              a;
        t_sel              b;
        t_mop              op;
        logic [MIDX_W-1:0] dst;
    } t_mstep;

    // Controller to datapath
    typedef struct packed {
        logic              cap_pose;
        logic              cap_node;
        logic              cinit;
        logic              cstep;
        logic              cstore;
        logic [1:0]        ang;
        logic [STEP_W-1:0] step;
        logic              mat_en;
        logic [MIDX_W-1:0] midx;
        logic              row_en;
        logic [1:0]        row;
        logic              load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_stat;

    // atan(2^-i) in degrees scaled by 2^24
    function automatic logic signed [CZ_W-1:0] erbt_atan(input logic [STEP_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        unique case (i)
            5'd0:  v = 33'sd754974720;
            5'd1:  v = 33'sd445687602;
            5'd2:  v = 33'sd235489088;
            5'd3:  v = 33'sd119537938;
            5'd4:  v = 33'sd60000934;
            5'd5:  v = 33'sd30029717;
            5'd6:  v = 33'sd15018523;
            5'd7:  v = 33'sd7509720;
            5'd8:  v = 33'sd3754917;
            5'd9:  v = 33'sd1877466;
            5'd10: v = 33'sd938734;
            5'd11: v = 33'sd469367;
            5'd12: v = 33'sd234684;
            5'd13: v = 33'sd117342;
            5'd14: v = 33'sd58671;
            5'd15: v = 33'sd29335;
            5'd16: v = 33'sd14668;
            5'd17: v = 33'sd7334;
            5'd18: v = 33'sd3667;
            5'd19: v = 33'sd1833;
            5'd20: v = 33'sd917;
            5'd21: v = 33'sd458;
            5'd22: v = 33'sd229;
            5'd23: v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Product schedule that builds the ZYX matrix
    function automatic t_mstep erbt_mat_step(input logic [MIDX_W-1:0] i);
        t_mstep s;
        unique case (i)
            4'd0:  s = '{SEL_CY,   SEL_CP, MOP_PUT,  4'd0};
            4'd1:  s = '{SEL_CY,   SEL_SP, MOP_TMP,  4'd0};
            4'd2:  s = '{SEL_SY,   SEL_SP, MOP_TMP,  4'd1};
            4'd3:  s = '{SEL_CYSP, SEL_SR, MOP_LOAD, 4'd0};
            4'd4:  s = '{SEL_SY,   SEL_CR, MOP_SUB,  4'd1};
            4'd5:  s = '{SEL_CYSP, SEL_CR, MOP_LOAD, 4'd0};
            4'd6:  s = '{SEL_SY,   SEL_SR, MOP_ADD,  4'd2};
            4'd7:  s = '{SEL_SY,   SEL_CP, MOP_PUT,  4'd3};
            4'd8:  s = '{SEL_SYSP, SEL_SR, MOP_LOAD, 4'd0};
            4'd9:  s = '{SEL_CY,   SEL_CR, MOP_ADD,  4'd4};
            4'd10: s = '{SEL_SYSP, SEL_CR, MOP_LOAD, 4'd0};
            4'd11: s = '{SEL_CY,   SEL_SR, MOP_SUB,  4'd5};
            4'd12: s = '{SEL_CP,   SEL_SR, MOP_PUT,  4'd7};
            4'd13: s = '{SEL_CP,   SEL_CR, MOP_PUT,  4'd8};
            4'd14: s = '{SEL_SP,   SEL_SP, MOP_NEG,  4'd6};
            default: s = '{SEL_SP, SEL_SP, MOP_TMP,  4'd0};
        endcase
        return s;
    endfunction

    // Clamp a sum of rounded products to the entry range
    function automatic t_ent erbt_clamp_ent(input logic signed [P18_W:0] v);
        logic signed [P18_W:0] c;
        if (v > ENT_MAX) begin
            c = ENT_MAX;
        end else if (v < ENT_MIN) begin
            c = ENT_MIN;
        end else begin
            c = v;
        end
        return c[ENT_W-1:0];
    endfunction

    // Round a CORDIC output to Q2.18, clamp to [-1,1], negate on fold
    function automatic t_ent erbt_round_sc(input logic signed [CX_W-1:0] v, input logic flip);
        logic signed [CX_W-1:0] r;
        logic signed [CX_W-1:0] c;
        r = (v + 34'sd2048) >>> 12;
        if (r > UNIT_POS) begin
            c = UNIT_POS;
        end else if (r < UNIT_NEG) begin
            c = UNIT_NEG;
        end else begin
            c = r;
        end
        if (flip) begin
            c = -c;
        end
        return c[ENT_W-1:0];
    endfunction

endpackage

>>> design/erbt_if.sv
// Valid/ready channel interfaces for pose/node words and result words.
interface erbt_in_if #(parameter int CW = 32);
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [CW-1:0]              shift_x;
    logic signed [CW-1:0]              shift_y;
    logic signed [CW-1:0]              shift_z;
    logic signed [erbt_pkg::ANG_W-1:0] roll_deg;
    logic signed [erbt_pkg::ANG_W-1:0] pitch_deg;
    logic signed [erbt_pkg::ANG_W-1:0] yaw_deg;
    logic signed [CW-1:0]              node_rx;
    logic signed [CW-1:0]              node_ry;
    logic signed [CW-1:0]              node_rz;
    logic                              last_node;

    modport source (output valid, operation, shift_x, shift_y, shift_z, roll_deg,
                    pitch_deg, yaw_deg, node_rx, node_ry, node_rz, last_node,
                    input ready);
    modport sink (input valid, operation, shift_x, shift_y, shift_z, roll_deg,
                  pitch_deg, yaw_deg, node_rx, node_ry, node_rz, last_node,
                  output ready);
endinterface

interface erbt_out_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] moved_x;
    logic signed [CW-1:0] moved_y;
    logic signed [CW-1:0] moved_z;
    logic                 node_is_last;

    modport source (output valid, moved_x, moved_y, moved_z, node_is_last, input ready);
    modport sink (input valid, moved_x, moved_y, moved_z, node_is_last, output ready);
endinterface

>>> design/erbt_ctrl.sv
// Sequencer for pose loads (CORDIC, matrix build) and node transforms.
module erbt_ctrl
    import erbt_pkg::*;
#(
    parameter int CORDIC_STEPS = 18
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CSW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CSW-1:0] STEP_LAST = CSW'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_CORD   = 4'd2;
    localparam logic [3:0] S_ROUND  = 4'd3;
    localparam logic [3:0] S_MAT    = 4'd4;
    localparam logic [3:0] S_MDRAIN = 4'd5;
    localparam logic [3:0] S_ROW    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_ang, n_ang;
    logic [CSW-1:0]    r_step, n_step;
    logic [MIDX_W-1:0] r_midx, n_midx;
    logic [1:0]        r_row, n_row;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ang   = r_ang;
        n_step  = r_step;
        n_midx  = r_midx;
        n_row   = r_row;
        o_cmd          = '0;
        o_cmd.ang      = r_ang;
        o_cmd.step     = STEP_W'(r_step);
        o_cmd.midx     = r_midx;
        o_cmd.row      = r_row;
        o_cmd.cap_pose = accept && !i_in_op;
        o_cmd.cap_node = accept && i_in_op;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ang = '0;
                    n_row = '0;
                    n_state = i_in_op ? S_ROW : S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.cinit = 1'b1;
                n_step  = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.cstep = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_ROUND;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.cstore = 1'b1;
                if (r_ang == 2'd2) begin
                    n_midx  = '0;
                    n_state = S_MAT;
                end else begin
                    n_ang   = r_ang + 1'b1;
                    n_state = S_PREP;
                end
            end
            S_MAT: begin
                o_cmd.mat_en = 1'b1;
                if (r_midx == MIDX_W'(MAT_STEPS - 1)) begin
                    n_state = S_MDRAIN;
                end else begin
                    n_midx = r_midx + 1'b1;
                end
            end
            S_MDRAIN: begin
                n_state = S_IDLE;
            end
            S_ROW: begin
                o_cmd.row_en = 1'b1;
                if (r_row == 2'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the word
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ang   <= '0;
            r_step  <= '0;
            r_midx  <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_ang   <= n_ang;
            r_step  <= n_step;
            r_midx  <= n_midx;
            r_row   <= n_row;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_stat.out_busy)
        else $error("output loaded while previous word still stalled");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("ready stayed high after an accepted word");

    a_cordic_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD && r_step == STEP_LAST) |=> (r_state == S_ROUND))
        else $error("CORDIC did not end after its last step");

endmodule

>>> design/erbt_dp.sv
// Datapath: angle fold, CORDIC, matrix products, node rows, output register.
module erbt_dp
    import erbt_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic signed [CW-1:0]     i_shift_x,
    input  logic signed [CW-1:0]     i_shift_y,
    input  logic signed [CW-1:0]     i_shift_z,
    input  logic signed [ANG_W-1:0]  i_roll,
    input  logic signed [ANG_W-1:0]  i_pitch,
    input  logic signed [ANG_W-1:0]  i_yaw,
    input  logic signed [CW-1:0]     i_node_rx,
    input  logic signed [CW-1:0]     i_node_ry,
    input  logic signed [CW-1:0]     i_node_rz,
    input  logic                     i_last,
    erbt_out_if.source               o_out
);

    localparam int MP_W  = CW + ENT_W;
    localparam int SUM_W = CW + ENT_W + 2;
    localparam int RND_W = SUM_W - 18;
    localparam int RES_W = RND_W + 1;
    localparam logic signed [RES_W-1:0] CMAX = RES_W'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [RES_W-1:0] CMIN = -CMAX - 1'b1;

    logic signed [ANG_W-1:0] r_ang [3];
    logic signed [CW-1:0]    r_off [3];
    logic signed [CW-1:0]    r_node [3];
    logic                    r_last;
    t_ent                    r_sin [3];
    t_ent                    r_cos [3];
    t_ent                    r_rot [9];
    t_ent                    r_cysp, r_sysp;
    logic signed [CX_W-1:0]  r_x, r_y;
    logic signed [CZ_W-1:0]  r_z;
    logic                    r_flip;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_pose) begin
            r_ang[0] <= i_roll;
            r_ang[1] <= i_pitch;
            r_ang[2] <= i_yaw;
        end
        if (i_cmd.cap_node) begin
            r_node[0] <= i_node_rx;
            r_node[1] <= i_node_ry;
            r_node[2] <= i_node_rz;
            r_last    <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= '0;
            end
        end else if (i_cmd.cap_pose) begin
            r_off[0] <= i_shift_x;
            r_off[1] <= i_shift_y;
            r_off[2] <= i_shift_z;
        end
    end

    // Wrap to [-180,180) and fold into [-90,90]
    logic signed [ANG_W-1:0] ang_sel;
    logic signed [AW_W-1:0]  a_ext, a_wrap, a_fold;
    logic                    fold;

    always_comb begin
        unique case (i_cmd.ang)
            2'd0:    ang_sel = r_ang[0];
            2'd1:    ang_sel = r_ang[1];
            default: ang_sel = r_ang[2];
        endcase
        a_ext = AW_W'(ang_sel) <<< 8;
        if (a_ext >= ANG_HALF) begin
            a_wrap = a_ext - ANG_FULL;
        end else if (a_ext < -ANG_HALF) begin
            a_wrap = a_ext + ANG_FULL;
        end else begin
            a_wrap = a_ext;
        end
        fold = 1'b0;
        if (a_wrap > ANG_QTR) begin
            a_fold = a_wrap - ANG_HALF;
            fold = 1'b1;
        end else if (a_wrap < -ANG_QTR) begin
            a_fold = a_wrap + ANG_HALF;
            fold = 1'b1;
        end else begin
            a_fold = a_wrap;
        end
    end

    // One CORDIC rotation a cycle
    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] atan_i;

    assign dx     = r_y >>> i_cmd.step;
    assign dy     = r_x >>> i_cmd.step;
    assign atan_i = erbt_atan(i_cmd.step);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cinit) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= a_fold[CZ_W-1:0];
            r_flip <= fold;
        end else if (i_cmd.cstep) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cstore) begin
            r_sin[i_cmd.ang] <= erbt_round_sc(r_y, r_flip);
            r_cos[i_cmd.ang] <= erbt_round_sc(r_x, r_flip);
        end
    end

    // Matrix build: multiply into a register, then round and combine in the next cycle
    function automatic t_ent pick(input t_sel s, input t_ent sr, input t_ent cr,
                                  input t_ent sp, input t_ent cp, input t_ent sy,
                                  input t_ent cy, input t_ent cysp, input t_ent sysp);
        t_ent v;
        unique case (s)
            SEL_SR:   v = sr;
            SEL_CR:   v = cr;
            SEL_SP:   v = sp;
            SEL_CP:   v = cp;
            SEL_SY:   v = sy;
            SEL_CY:   v = cy;
            SEL_CYSP: v = cysp;
            default:  v = sysp;
        endcase
        return v;
    endfunction

    t_mstep                    mstep;
    t_ent                      op_a, op_b;
    logic signed [PROD_W-1:0]  r_prod;
    t_mstep                    r_mstep;
    logic                      r_mvalid;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [P18_W-1:0]   p18;
    logic signed [P18_W:0]     r_acc;

    assign mstep = erbt_mat_step(i_cmd.midx);
    assign op_a  = pick(mstep.a, r_sin[0], r_cos[0], r_sin[1], r_cos[1], r_sin[2],
                        r_cos[2], r_cysp, r_sysp);
    assign op_b  = pick(mstep.b, r_sin[0], r_cos[0], r_sin[1], r_cos[1], r_sin[2],
                        r_cos[2], r_cysp, r_sysp);
    assign prod_rnd = (r_prod + PROD_W'(131072)) >>> 18;
    assign p18      = prod_rnd[P18_W-1:0];

    always_ff @(posedge i_clk) begin
        r_prod  <= op_a * op_b;
        r_mstep <= mstep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else begin
            r_mvalid <= i_cmd.mat_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= '0;
            end
        end else if (r_mvalid) begin
            unique case (r_mstep.op)
                MOP_TMP: begin
                    if (r_mstep.dst == 4'd0) begin
                        r_cysp <= p18[ENT_W-1:0];
                    end else begin
                        r_sysp <= p18[ENT_W-1:0];
                    end
                end
                MOP_LOAD: r_acc <= (P18_W+1)'(p18);
                MOP_PUT:  r_rot[r_mstep.dst] <= erbt_clamp_ent((P18_W+1)'(p18));
                MOP_ADD:  r_rot[r_mstep.dst] <= erbt_clamp_ent(r_acc + (P18_W+1)'(p18));
                MOP_SUB:  r_rot[r_mstep.dst] <= erbt_clamp_ent(r_acc - (P18_W+1)'(p18));
                MOP_NEG:  r_rot[r_mstep.dst] <= erbt_clamp_ent(-((P18_W+1)'(r_sin[1])));
                default: ;
            endcase
        end
    end

    // Node rows: three multipliers per row, one row a cycle
    logic [MIDX_W-1:0]        base;
    logic signed [MP_W-1:0]   mp0, mp1, mp2;
    logic signed [SUM_W-1:0]  r_sum;
    logic [1:0]               r_srow;
    logic                     r_svalid;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [RES_W-1:0]  res;
    logic signed [CW-1:0]     res_sat;
    logic signed [CW-1:0]     r_res [3];

    assign base = MIDX_W'(i_cmd.row) * MIDX_W'(3);
    assign mp0  = r_node[0] * r_rot[base];
    assign mp1  = r_node[1] * r_rot[base + MIDX_W'(1)];
    assign mp2  = r_node[2] * r_rot[base + MIDX_W'(2)];

    always_ff @(posedge i_clk) begin
        r_sum  <= SUM_W'(mp0) + SUM_W'(mp1) + SUM_W'(mp2);
        r_srow <= i_cmd.row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svalid <= 1'b0;
        end else begin
            r_svalid <= i_cmd.row_en;
        end
    end

    // Round to Q16.16, add the offset, saturate
    always_comb begin
        sum_rnd = (r_sum + SUM_W'(131072)) >>> 18;
        res = RES_W'($signed(sum_rnd[RND_W-1:0])) + RES_W'(r_off[r_srow]);
        if (res > CMAX) begin
            res_sat = CMAX[CW-1:0];
        end else if (res < CMIN) begin
            res_sat = CMIN[CW-1:0];
        end else begin
            res_sat = res[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_svalid) begin
            r_res[r_srow] <= res_sat;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out.moved_x      <= r_res[0];
            o_out.moved_y      <= r_res[1];
            o_out.moved_z      <= r_res[2];
            o_out.node_is_last <= r_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_stat.out_busy = r_out_valid && !o_out.ready;

endmodule

>>> design/euler_rigid_body_node_transform.sv
// Top level of the ZYX Euler rigid-body node transform.
//
// Input channel i_in carries one word per item. operation 0 loads a pose:
// translation plus roll, pitch and yaw in degrees (Q10.16). The block wraps
// each angle, runs a CORDIC rotator for sine and cosine, and builds the
// rotation matrix with one shared 20x20 multiplier. A pose load produces no
// result; its three angles take turns on the single CORDIC unit, and all
// matrix products take turns on the single matrix multiplier.
// operation 1 transforms one node: three multipliers form one matrix row per
// cycle; the row sums are registered, rounded and stored, then the moved node
// is loaded into o_out once the register is free, and a new word is taken.
// Results are Q16.16 saturated to COORD_WIDTH; node_is_last copies last_node.
// The block takes one item at a time; ready is high while it is idle.
// The output register holds a finished word while the receiver stalls, and
// the next item is accepted meanwhile; a node that finishes while the old
// word still waits holds in its last stage until the register frees.
// Reset (synchronous, active low) clears the matrix and offset to zero, so
// nodes sent before any pose come out as zero.
module euler_rigid_body_node_transform
    import erbt_pkg::*;
#(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    erbt_in_if.sink     i_in,
    erbt_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    erbt_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    erbt_dp #(
        .CW(COORD_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_shift_x (i_in.shift_x),
        .i_shift_y (i_in.shift_y),
        .i_shift_z (i_in.shift_z),
        .i_roll    (i_in.roll_deg),
        .i_pitch   (i_in.pitch_deg),
        .i_yaw     (i_in.yaw_deg),
        .i_node_rx (i_in.node_rx),
        .i_node_ry (i_in.node_ry),
        .i_node_rz (i_in.node_rz),
        .i_last    (i_in.last_node),
        .o_out     (o_out)
    );

endmodule
